### hw/rtl/fbpa_pkg.sv
package fbpa_pkg;

  localparam int unsigned POOL_BLOCKS = 16;
  localparam int unsigned BLOCK_BYTES = 64;

  localparam int unsigned IDX_W  = $clog2(POOL_BLOCKS);
  localparam int unsigned LINK_W = IDX_W + 1;
  localparam int unsigned BLK_W  = 4;
  localparam int unsigned OFF_W  = 10;
  localparam int unsigned CNT_W  = 5;

  localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(POOL_BLOCKS);
  localparam logic [LINK_W-1:0] TOP_BLOCK = LINK_W'(POOL_BLOCKS - 1);
  localparam logic [CNT_W-1:0]  CNT_MAX   = CNT_W'(POOL_BLOCKS);

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  typedef struct packed {
    logic accept;
  } cmd_t;

endpackage

### hw/rtl/fbpa_ctrl.sv
module fbpa_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output fbpa_pkg::cmd_t cmd_o
);
  import fbpa_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_HOLD
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  assign in_ready_o   = (state_q == ST_IDLE) || out_ready_i;
  assign cmd_o.accept = in_valid_i && in_ready_o;
  assign out_valid_o  = out_valid_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (cmd_o.accept) state_d = ST_HOLD;
      end
      ST_HOLD: begin
        if (out_ready_i && !cmd_o.accept) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
    out_valid_d = (state_d == ST_HOLD);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

### hw/rtl/fbpa_dp.sv
module fbpa_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  fbpa_pkg::cmd_t                cmd_i,
  input  logic                          kind_i,
  input  logic                          ptr_present_i,
  input  logic [fbpa_pkg::BLK_W-1:0]    block_index_i,
  output logic                          granted_o,
  output logic                          exhausted_o,
  output logic [fbpa_pkg::BLK_W-1:0]    given_index_o,
  output logic [fbpa_pkg::OFF_W-1:0]    byte_offset_o,
  output logic [fbpa_pkg::CNT_W-1:0]    used_blocks_o
);
  import fbpa_pkg::*;

  // link table entries read their reset link until first written
  logic [LINK_W-1:0]      lt_q [POOL_BLOCKS];
  logic [POOL_BLOCKS-1:0] lt_vld_q;
  logic [LINK_W-1:0]      head_q, head_d;
  logic [CNT_W-1:0]       used_q, used_d;

  logic             granted_q, exhausted_q;
  logic [BLK_W-1:0] given_q;
  logic [OFF_W-1:0] offset_q;

  logic [IDX_W-1:0]  rd_idx, wr_idx;
  logic [LINK_W-1:0] link_rd;
  logic              empty, free_ok, alloc_ok, wr_en;
  logic              granted_d, exhausted_d;
  logic [BLK_W-1:0]  given_d;
  logic [OFF_W-1:0]  offset_d;

  assign rd_idx = head_q[IDX_W-1:0];
  assign wr_idx = IDX_W'(block_index_i);
  assign empty  = (head_q >= NULL_LINK);

  always_comb begin
    if (lt_vld_q[rd_idx]) begin
      link_rd = lt_q[rd_idx];
    end else if (rd_idx == '0) begin
      link_rd = NULL_LINK;
    end else begin
      link_rd = LINK_W'(rd_idx) - LINK_W'(1);
    end
  end

  assign alloc_ok = (kind_i == KIND_ALLOC) && !empty;
  assign free_ok  = (kind_i == KIND_FREE) && ptr_present_i &&
                    (32'(block_index_i) < POOL_BLOCKS);
  assign wr_en    = cmd_i.accept && free_ok;

  always_comb begin
    head_d      = head_q;
    used_d      = used_q;
    granted_d   = 1'b0;
    exhausted_d = 1'b0;
    given_d     = '0;
    offset_d    = '0;
    if (alloc_ok) begin
      head_d    = link_rd;
      granted_d = 1'b1;
      given_d   = BLK_W'(rd_idx);
      offset_d  = OFF_W'(32'(rd_idx) * BLOCK_BYTES);
      if (used_q < CNT_MAX) used_d = used_q + CNT_W'(1);
    end else if (kind_i == KIND_ALLOC) begin
      exhausted_d = 1'b1;
    end else if (free_ok) begin
      head_d    = LINK_W'(wr_idx);
      granted_d = 1'b1;
      if (used_q != '0) used_d = used_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q   <= TOP_BLOCK;
      used_q   <= '0;
      lt_vld_q <= '0;
    end else if (cmd_i.accept) begin
      head_q <= head_d;
      used_q <= used_d;
      if (wr_en) lt_vld_q[wr_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) lt_q[wr_idx] <= head_q;
    if (cmd_i.accept) begin
      granted_q   <= granted_d;
      exhausted_q <= exhausted_d;
      given_q     <= given_d;
      offset_q    <= offset_d;
    end
  end

  assign granted_o     = granted_q;
  assign exhausted_o   = exhausted_q;
  assign given_index_o = given_q;
  assign byte_offset_o = offset_q;
  assign used_blocks_o = used_q;

endmodule

### hw/rtl/fixed_block_pool_allocator_core.sv
// Result: registered, valid in the cycle after the request word is accepted.
// Throughput: 1 word per cycle while no result word is stalled by out_ready_i;
//   head register and link register file are read and updated in the accept cycle.
// Reset: asynchronous, active low; free list restored at once through
//   per-entry valid bits, no clearing pass.
module fixed_block_pool_allocator_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       kind_i,
  input  logic                       ptr_present_i,
  input  logic [fbpa_pkg::BLK_W-1:0] block_index_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic                       granted_o,
  output logic                       exhausted_o,
  output logic [fbpa_pkg::BLK_W-1:0] given_index_o,
  output logic [fbpa_pkg::OFF_W-1:0] byte_offset_o,
  output logic [fbpa_pkg::CNT_W-1:0] used_blocks_o
);
  import fbpa_pkg::*;

  cmd_t cmd;

  fbpa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  fbpa_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .kind_i        (kind_i),
    .ptr_present_i (ptr_present_i),
    .block_index_i (block_index_i),
    .granted_o     (granted_o),
    .exhausted_o   (exhausted_o),
    .given_index_o (given_index_o),
    .byte_offset_o (byte_offset_o),
    .used_blocks_o (used_blocks_o)
  );

endmodule

### hw/rtl/fbpa_checker.sv
module fbpa_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_o,
  input logic                       out_valid_o,
  input logic                       out_ready_i,
  input logic                       granted_o,
  input logic                       exhausted_o,
  input logic [fbpa_pkg::BLK_W-1:0] given_index_o,
  input logic [fbpa_pkg::OFF_W-1:0] byte_offset_o,
  input logic [fbpa_pkg::CNT_W-1:0] used_blocks_o
);
  import fbpa_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result word dropped while stalled");

  a_accept_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> out_valid_o)
    else $error("accepted word gave no result");

  a_grant_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(granted_o && exhausted_o))
    else $error("granted and exhausted together");

  a_exhaust_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && exhausted_o |-> given_index_o == '0 && byte_offset_o == '0)
    else $error("exhausted result carries a block");

  a_offset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> byte_offset_o == OFF_W'(32'(given_index_o) * BLOCK_BYTES)
                    && used_blocks_o <= CNT_MAX)
    else $error("offset or count inconsistent");

endmodule

bind fixed_block_pool_allocator_core fbpa_checker u_fbpa_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_ready_o    (in_ready_o),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .granted_o     (granted_o),
  .exhausted_o   (exhausted_o),
  .given_index_o (given_index_o),
  .byte_offset_o (byte_offset_o),
  .used_blocks_o (used_blocks_o)
);

### tb/tb_top.sv
module tb_top;
  import fbpa_pkg::*;

  typedef struct packed {
    logic             granted;
    logic             exhausted;
    logic [BLK_W-1:0] given;
    logic [OFF_W-1:0] offset;
    logic [CNT_W-1:0] used;
  } pool_result_t;

  typedef struct {
    logic             kind;
    logic             ptr;
    logic [BLK_W-1:0] idx;
    bit               typed;
    pool_result_t     exp;
  } stim_row_t;

  localparam int RAND_WORDS = 1875;
  localparam int CALM_WORDS = 150;
  localparam int WDOG_LIMIT = 2000;

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             in_valid;
  logic             in_ready;
  logic             kind;
  logic             ptr_present;
  logic [BLK_W-1:0] block_index;
  logic             out_valid;
  logic             out_ready;
  logic             granted;
  logic             exhausted;
  logic [BLK_W-1:0] given_index;
  logic [OFF_W-1:0] byte_offset;
  logic [CNT_W-1:0] used_blocks;

  // predicted pool state
  logic [LINK_W-1:0] free_link [POOL_BLOCKS];
  logic [LINK_W-1:0] free_head;
  logic [CNT_W-1:0]  blocks_in_use;

  pool_result_t     expected_q [$];
  logic [BLK_W-1:0] held_blocks [$];
  stim_row_t        dir_rows [$];
  int               errors = 0;
  int               stall_left = 0;
  int               idle_cycles = 0;
  bit               calm = 1'b0;

  fixed_block_pool_allocator_core i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .kind_i        (kind),
    .ptr_present_i (ptr_present),
    .block_index_i (block_index),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .granted_o     (granted),
    .exhausted_o   (exhausted),
    .given_index_o (given_index),
    .byte_offset_o (byte_offset),
    .used_blocks_o (used_blocks)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  task automatic pool_reset();
    free_link[0] = NULL_LINK;
    for (int i = 1; i < POOL_BLOCKS; i++) free_link[i] = LINK_W'(i - 1);
    free_head     = TOP_BLOCK;
    blocks_in_use = '0;
  endtask

  function automatic pool_result_t pool_step(logic k, logic p, logic [BLK_W-1:0] idx);
    pool_result_t r;
    r = '0;
    if (k == KIND_ALLOC) begin
      if (free_head >= NULL_LINK) begin
        r.exhausted = 1'b1;
      end else begin
        r.given   = free_head[BLK_W-1:0];
        r.offset  = OFF_W'(free_head * BLOCK_BYTES);
        free_head = free_link[free_head[IDX_W-1:0]];
        if (blocks_in_use < CNT_MAX) blocks_in_use = blocks_in_use + CNT_W'(1);
        r.granted = 1'b1;
      end
    end else if (p && int'(idx) < POOL_BLOCKS) begin
      free_link[idx] = free_head;
      free_head      = LINK_W'(idx);
      if (blocks_in_use != '0) blocks_in_use = blocks_in_use - CNT_W'(1);
      r.granted = 1'b1;
    end
    r.used = blocks_in_use;
    return r;
  endfunction

  function automatic stim_row_t row(logic k, logic p, logic [BLK_W-1:0] idx, bit typed,
                                    logic g, logic ex, logic [BLK_W-1:0] gi,
                                    logic [OFF_W-1:0] off, logic [CNT_W-1:0] used);
    stim_row_t s;
    s.kind  = k;
    s.ptr   = p;
    s.idx   = idx;
    s.typed = typed;
    s.exp   = '{granted: g, exhausted: ex, given: gi, offset: off, used: used};
    return s;
  endfunction

  task automatic send_word(logic k, logic p, logic [BLK_W-1:0] idx, bit typed,
                           pool_result_t typed_exp);
    pool_result_t r;
    in_valid    <= 1'b1;
    kind        <= k;
    ptr_present <= p;
    block_index <= idx;
    do @(posedge clk_i); while (!in_ready);
    r = pool_step(k, p, idx);
    if (k == KIND_ALLOC && r.granted) held_blocks.push_back(r.given);
    expected_q.push_back(typed ? typed_exp : r);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  task automatic cmp_field(string name, int exp_v, int act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  always @(posedge clk_i) begin
    pool_result_t e;
    if (rst_ni && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result word, actual %b %b %0d %0d %0d", $time,
                 granted, exhausted, given_index, byte_offset, used_blocks);
        errors++;
      end else begin
        e = expected_q.pop_front();
        cmp_field("granted", int'(e.granted), int'(granted));
        cmp_field("exhausted", int'(e.exhausted), int'(exhausted));
        cmp_field("given_index", int'(e.given), int'(given_index));
        cmp_field("byte_offset", int'(e.offset), int'(byte_offset));
        cmp_field("used_blocks", int'(e.used), int'(used_blocks));
      end
    end
    if (calm) begin
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_ready <= 1'b1;
      if ($urandom_range(0, 3) == 0) stall_left <= $urandom_range(1, 4);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_LIMIT) begin
          $display("[fixed_block_pool_allocator_core] ERROR");
          $finish;
        end
      end
    end
  end

  initial begin
    logic             k;
    logic             p;
    logic [BLK_W-1:0] idx;
    int               alloc_pct;
    int               phase_left;
    int               pick;
    int               j;
    rst_ni      = 1'b0;
    in_valid    = 1'b0;
    kind        = KIND_ALLOC;
    ptr_present = 1'b0;
    block_index = '0;
    out_ready   = 1'b0;
    alloc_pct   = 50;
    phase_left  = 0;
    pool_reset();

    // drain the pool from the top block down, then hit the empty list
    for (int i = 0; i < POOL_BLOCKS; i++)
      dir_rows.push_back(row(KIND_ALLOC, i[0], BLK_W'(i), 1'b1, 1'b1, 1'b0,
                             BLK_W'(15 - i), OFF_W'((15 - i) * 64), CNT_W'(i + 1)));
    dir_rows.push_back(row(KIND_ALLOC, 1'b1, 4'hf, 1'b1, 1'b0, 1'b1, '0, '0, 5'd16));
    dir_rows.push_back(row(KIND_FREE, 1'b1, 4'h0, 1'b1, 1'b1, 1'b0, '0, '0, 5'd15));
    dir_rows.push_back(row(KIND_FREE, 1'b0, 4'hf, 1'b1, 1'b0, 1'b0, '0, '0, 5'd15));
    dir_rows.push_back(row(KIND_ALLOC, 1'b0, 4'h0, 1'b0, 1'b0, 1'b0, '0, '0, '0));
    // double free makes block 3 link to itself; count then saturates at the top
    dir_rows.push_back(row(KIND_FREE, 1'b1, 4'h3, 1'b0, 1'b0, 1'b0, '0, '0, '0));
    dir_rows.push_back(row(KIND_FREE, 1'b1, 4'h3, 1'b0, 1'b0, 1'b0, '0, '0, '0));
    dir_rows.push_back(row(KIND_ALLOC, 1'b0, 4'h0, 1'b0, 1'b0, 1'b0, '0, '0, '0));
    dir_rows.push_back(row(KIND_ALLOC, 1'b1, 4'ha, 1'b0, 1'b0, 1'b0, '0, '0, '0));
    dir_rows.push_back(row(KIND_ALLOC, 1'b0, 4'h5, 1'b0, 1'b0, 1'b0, '0, '0, '0));

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[n])
      send_word(dir_rows[n].kind, dir_rows[n].ptr, dir_rows[n].idx, dir_rows[n].typed,
                dir_rows[n].exp);

    for (int n = 0; n < RAND_WORDS; n++) begin
      if (n == RAND_WORDS - CALM_WORDS) calm = 1'b1;
      if (phase_left == 0) begin
        phase_left = $urandom_range(10, 60);
        case ($urandom_range(0, 2))
          0: alloc_pct = 20;
          1: alloc_pct = 50;
          default: alloc_pct = 80;
        endcase
      end
      phase_left--;
      p   = 1'($urandom_range(0, 1));
      idx = BLK_W'($urandom_range(0, POOL_BLOCKS - 1));
      if ($urandom_range(0, 99) < alloc_pct) begin
        k = KIND_ALLOC;
      end else begin
        k    = KIND_FREE;
        pick = $urandom_range(0, 99);
        if (pick < 70 && held_blocks.size() > 0) begin
          j   = $urandom_range(0, held_blocks.size() - 1);
          idx = held_blocks[j];
          held_blocks.delete(j);
          p   = 1'b1;
        end else if (pick < 80) begin
          p = 1'b0;
        end else begin
          p = 1'b1;
        end
      end
      send_word(k, p, idx, 1'b0, '0);
    end
    in_valid <= 1'b0;

    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (errors == 0) begin
      $display("[fixed_block_pool_allocator_core] OK");
    end else begin
      $display("[fixed_block_pool_allocator_core] ERROR");
    end
    $finish;
  end

endmodule

### sim.f
hw/rtl/fbpa_pkg.sv
hw/rtl/fbpa_ctrl.sv
hw/rtl/fbpa_dp.sv
hw/rtl/fixed_block_pool_allocator_core.sv
hw/rtl/fbpa_checker.sv
tb/tb_top.sv
